// File: hdl/nearest_resize_address_gen_macros.svh
// Assertion macros for the resize address generator.
// Both expect clk and rst_n in scope at the point of use.
`ifndef NEAREST_RESIZE_ADDRESS_GEN_MACROS_SVH
`define NEAREST_RESIZE_ADDRESS_GEN_MACROS_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define NRA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nra: same-cycle check failed");

// ante implies cons in the next cycle
`define NRA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nra: next-cycle check failed");

`else

`define NRA_ASSERT_IMP(name, ante, cons)
`define NRA_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: hdl/nra_pkg.sv
package nra_pkg;

    // default limits for the top-level parameters
    localparam int unsigned MAX_DIM_DEF      = 4096;
    localparam int unsigned MAX_CHANNELS_DEF = 16;

    // register port
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned REG_SEL_W = 3;

    // field widths
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned DIM_W        = 13;
    localparam int unsigned NCH_W        = 5;
    localparam int unsigned STRIDE_REG_W = 17;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned CIDX_W       = 4;
    localparam int unsigned COORD_W      = 12;
    localparam int unsigned OFS_W        = 28;

    // derived datapath widths
    localparam int unsigned NUM_W   = COORD_W + DIM_W;   // index * size
    localparam int unsigned QUO_W   = DIM_W;             // quotient bits kept
    localparam int unsigned CMP_W   = NUM_W + 1;         // compare width in divider
    localparam int unsigned PITCH_W = DIM_W + NCH_W;     // width * channels
    localparam int unsigned AREA_W  = 2 * DIM_W;         // size * size

    // mode bits
    localparam int unsigned MODE_TRANSPOSE = 0;
    localparam int unsigned MODE_LOCK      = 1;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_SRC_BASE,
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT,
        REG_NUM_CHANNELS,
        REG_ROW_STRIDE,
        REG_MODE
    } reg_sel_t;

    typedef struct packed {
        logic [ADDR_W-1:0]       src_base;
        logic [DIM_W-1:0]        src_width;
        logic [DIM_W-1:0]        src_height;
        logic [DIM_W-1:0]        dst_width;
        logic [DIM_W-1:0]        dst_height;
        logic [NCH_W-1:0]        num_channels;
        logic [STRIDE_REG_W-1:0] row_stride;
        logic [MODE_W-1:0]       mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        src_base:     '0,
        src_width:    DIM_W'(1),
        src_height:   DIM_W'(1),
        dst_width:    DIM_W'(1),
        dst_height:   DIM_W'(1),
        num_channels: NCH_W'(1),
        row_stride:   '0,
        mode:         '0
    };

    typedef struct packed {
        logic [CIDX_W-1:0]  chan_index;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_address;
        logic [OFS_W-1:0]  dst_offset;
        logic              valid_res;
    } result_t;

    // fields that ride along with the divider
    typedef struct packed {
        logic [CIDX_W-1:0]  chan;
        logic [OFS_W-1:0]   dst_offset;
        logic [PITCH_W-1:0] pitch;
        logic               ok;
    } side_t;

    // one divider stage: vertical (h) and horizontal (w) lanes
    typedef struct packed {
        logic [NUM_W-1:0] rem_h;
        logic [NUM_W-1:0] rem_w;
        logic [DIM_W-1:0] den_h;
        logic [DIM_W-1:0] den_w;
        logic [QUO_W-1:0] quo_h;
        logic [QUO_W-1:0] quo_w;
        logic             ovf;
        side_t            side;
    } div_t;

endpackage

// File: hdl/nra_cfg.sv
module nra_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nra_pkg::PADDR_W-1:0]   paddr,
    input  logic [nra_pkg::DATA_W-1:0]    pwdata,
    output logic [nra_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output nra_pkg::cfg_t                 cfg
);

    nra_pkg::cfg_t    cfg_reg;
    nra_pkg::cfg_t    cfg_next;
    nra_pkg::reg_sel_t sel;
    logic             wr_en;

    assign pready = 1'b1;
    assign sel    = nra_pkg::reg_sel_t'(paddr[nra_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                nra_pkg::REG_SRC_BASE:
                    cfg_next.src_base = pwdata[nra_pkg::ADDR_W-1:0];
                nra_pkg::REG_SRC_WIDTH:
                    cfg_next.src_width = pwdata[nra_pkg::DIM_W-1:0];
                nra_pkg::REG_SRC_HEIGHT:
                    cfg_next.src_height = pwdata[nra_pkg::DIM_W-1:0];
                nra_pkg::REG_DST_WIDTH:
                    cfg_next.dst_width = pwdata[nra_pkg::DIM_W-1:0];
                nra_pkg::REG_DST_HEIGHT:
                    cfg_next.dst_height = pwdata[nra_pkg::DIM_W-1:0];
                nra_pkg::REG_NUM_CHANNELS:
                    cfg_next.num_channels = pwdata[nra_pkg::NCH_W-1:0];
                nra_pkg::REG_ROW_STRIDE:
                    cfg_next.row_stride = pwdata[nra_pkg::STRIDE_REG_W-1:0];
                nra_pkg::REG_MODE:
                    cfg_next.mode = pwdata[nra_pkg::MODE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= nra_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // readback
    always_comb
    begin
        case (sel)
            nra_pkg::REG_SRC_BASE:
                prdata = nra_pkg::DATA_W'(cfg_reg.src_base);
            nra_pkg::REG_SRC_WIDTH:
                prdata = nra_pkg::DATA_W'(cfg_reg.src_width);
            nra_pkg::REG_SRC_HEIGHT:
                prdata = nra_pkg::DATA_W'(cfg_reg.src_height);
            nra_pkg::REG_DST_WIDTH:
                prdata = nra_pkg::DATA_W'(cfg_reg.dst_width);
            nra_pkg::REG_DST_HEIGHT:
                prdata = nra_pkg::DATA_W'(cfg_reg.dst_height);
            nra_pkg::REG_NUM_CHANNELS:
                prdata = nra_pkg::DATA_W'(cfg_reg.num_channels);
            nra_pkg::REG_ROW_STRIDE:
                prdata = nra_pkg::DATA_W'(cfg_reg.row_stride);
            nra_pkg::REG_MODE:
                prdata = nra_pkg::DATA_W'(cfg_reg.mode);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: hdl/nra_front.sv
module nra_front #(
    parameter int unsigned MAX_DIM      = nra_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_CHANNELS = nra_pkg::MAX_CHANNELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  nra_pkg::cfg_t  cfg,
    input  logic           advance,
    input  logic           in_valid,
    input  nra_pkg::item_t in_data,
    output logic           out_valid,
    output nra_pkg::div_t  out_data
);

    // stage 1: config checks and the size products
    typedef struct packed {
        nra_pkg::item_t                 item;
        logic [nra_pkg::AREA_W-1:0]     prod_a;
        logic [nra_pkg::AREA_W-1:0]     prod_b;
        logic [nra_pkg::AREA_W-1:0]     area;
        logic [nra_pkg::NUM_W-1:0]      row_dw;
        logic [nra_pkg::PITCH_W-1:0]    pitch_def;
        logic                           ok;
    } s1_t;

    // stage 2: ratios picked, plane offset and pitch
    typedef struct packed {
        logic [nra_pkg::CIDX_W-1:0]     chan;
        logic [nra_pkg::COORD_W-1:0]    col;
        logic [nra_pkg::COORD_W-1:0]    ih;
        logic [nra_pkg::COORD_W-1:0]    iw;
        logic [nra_pkg::DIM_W-1:0]      hn;
        logic [nra_pkg::DIM_W-1:0]      hd;
        logic [nra_pkg::DIM_W-1:0]      wn;
        logic [nra_pkg::DIM_W-1:0]      wd;
        logic [nra_pkg::OFS_W-1:0]      chan_area;
        logic [nra_pkg::NUM_W-1:0]      row_dw;
        logic [nra_pkg::PITCH_W-1:0]    pitch;
        logic                           ok;
    } s2_t;

    s1_t           s1_reg, s1_next;
    s2_t           s2_reg, s2_next;
    nra_pkg::div_t s3_reg, s3_next;
    logic [2:0]    v_reg;

    function automatic logic dim_ok(input logic [nra_pkg::DIM_W-1:0] d);
        dim_ok = (d != '0) && (32'(d) <= MAX_DIM);
    endfunction

    // stage 1
    always_comb
    begin
        s1_next.item      = in_data;
        s1_next.prod_a    = nra_pkg::AREA_W'(cfg.src_width) * nra_pkg::AREA_W'(cfg.dst_height);
        s1_next.prod_b    = nra_pkg::AREA_W'(cfg.dst_width) * nra_pkg::AREA_W'(cfg.src_height);
        s1_next.area      = nra_pkg::AREA_W'(cfg.dst_width) * nra_pkg::AREA_W'(cfg.dst_height);
        s1_next.row_dw    = nra_pkg::NUM_W'(in_data.out_row) * nra_pkg::NUM_W'(cfg.dst_width);
        s1_next.pitch_def = nra_pkg::PITCH_W'(cfg.src_width)
                          * nra_pkg::PITCH_W'(cfg.num_channels);
        s1_next.ok        = dim_ok(cfg.src_width) && dim_ok(cfg.src_height)
                         && dim_ok(cfg.dst_width) && dim_ok(cfg.dst_height)
                         && (cfg.num_channels != '0)
                         && (32'(cfg.num_channels) <= MAX_CHANNELS)
                         && (nra_pkg::NCH_W'(in_data.chan_index) < cfg.num_channels)
                         && ((cfg.row_stride == '0)
                             || (cfg.row_stride >= nra_pkg::STRIDE_REG_W'(cfg.src_width)));
    end

    // stage 2: axis swap and scale lock
    always_comb
    begin
        logic transpose;
        logic lock;
        logic wide;
        transpose = cfg.mode[nra_pkg::MODE_TRANSPOSE];
        lock      = cfg.mode[nra_pkg::MODE_LOCK];
        wide      = s1_reg.prod_a > s1_reg.prod_b;

        s2_next.chan = s1_reg.item.chan_index;
        s2_next.col  = s1_reg.item.out_col;
        s2_next.ih   = transpose ? s1_reg.item.out_col : s1_reg.item.out_row;
        s2_next.iw   = transpose ? s1_reg.item.out_row : s1_reg.item.out_col;
        s2_next.wn   = cfg.src_width;
        s2_next.hn   = cfg.src_height;
        s2_next.wd   = transpose ? cfg.dst_height : cfg.dst_width;
        s2_next.hd   = transpose ? cfg.dst_width : cfg.dst_height;
        if (lock)
        begin
            if (wide)
            begin
                s2_next.hn = s2_next.wn;
                s2_next.hd = s2_next.wd;
            end
            else
            begin
                s2_next.wn = s2_next.hn;
                s2_next.wd = s2_next.hd;
            end
        end
        s2_next.chan_area = nra_pkg::OFS_W'(s1_reg.area)
                          * nra_pkg::OFS_W'(s1_reg.item.chan_index);
        s2_next.row_dw    = s1_reg.row_dw;
        s2_next.pitch     = (cfg.row_stride == '0) ? s1_reg.pitch_def
                                                   : nra_pkg::PITCH_W'(cfg.row_stride);
        s2_next.ok        = s1_reg.ok;
    end

    // stage 3: dividends and destination offset
    always_comb
    begin
        s3_next.rem_h = nra_pkg::NUM_W'(s2_reg.ih) * nra_pkg::NUM_W'(s2_reg.hn);
        s3_next.rem_w = nra_pkg::NUM_W'(s2_reg.iw) * nra_pkg::NUM_W'(s2_reg.wn);
        s3_next.den_h = s2_reg.hd;
        s3_next.den_w = s2_reg.wd;
        s3_next.quo_h = '0;
        s3_next.quo_w = '0;
        s3_next.ovf   = 1'b0;
        s3_next.side.chan       = s2_reg.chan;
        s3_next.side.dst_offset = s2_reg.chan_area + nra_pkg::OFS_W'(s2_reg.row_dw)
                                + nra_pkg::OFS_W'(s2_reg.col);
        s3_next.side.pitch      = s2_reg.pitch;
        s3_next.side.ok         = s2_reg.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = s3_reg;

endmodule

// File: hdl/nra_div.sv
module nra_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  nra_pkg::div_t in_data,
    output logic          out_valid,
    output nra_pkg::div_t out_data
);

    // one quotient bit per stage in each lane, most significant first
    nra_pkg::div_t              src     [nra_pkg::QUO_W];
    nra_pkg::div_t              st_next [nra_pkg::QUO_W];
    nra_pkg::div_t              st_reg  [nra_pkg::QUO_W];
    logic [nra_pkg::QUO_W-1:0]  v_reg;
    logic                       ovf_h;
    logic                       ovf_w;

    always_comb
    begin
        src[0] = in_data;
        for (int k = 1; k < nra_pkg::QUO_W; k++)
        begin
            src[k] = st_reg[k-1];
        end
    end

    // quotient would need more bits than the source size has: out of image
    assign ovf_h = nra_pkg::CMP_W'(in_data.rem_h)
                >= (nra_pkg::CMP_W'(in_data.den_h) << nra_pkg::QUO_W);
    assign ovf_w = nra_pkg::CMP_W'(in_data.rem_w)
                >= (nra_pkg::CMP_W'(in_data.den_w) << nra_pkg::QUO_W);

    // restoring compare and subtract
    always_comb
    begin
        for (int k = 0; k < nra_pkg::QUO_W; k++)
        begin
            logic [nra_pkg::CMP_W-1:0] sub_h;
            logic [nra_pkg::CMP_W-1:0] sub_w;
            sub_h = nra_pkg::CMP_W'(src[k].den_h) << (nra_pkg::QUO_W - 1 - k);
            sub_w = nra_pkg::CMP_W'(src[k].den_w) << (nra_pkg::QUO_W - 1 - k);
            st_next[k] = src[k];
            if (nra_pkg::CMP_W'(src[k].rem_h) >= sub_h)
            begin
                st_next[k].rem_h = src[k].rem_h - nra_pkg::NUM_W'(sub_h);
                st_next[k].quo_h[nra_pkg::QUO_W-1-k] = 1'b1;
            end
            if (nra_pkg::CMP_W'(src[k].rem_w) >= sub_w)
            begin
                st_next[k].rem_w = src[k].rem_w - nra_pkg::NUM_W'(sub_w);
                st_next[k].quo_w[nra_pkg::QUO_W-1-k] = 1'b1;
            end
        end
        st_next[0].ovf = ovf_h || ovf_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[nra_pkg::QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < nra_pkg::QUO_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = v_reg[nra_pkg::QUO_W-1];
    assign out_data  = st_reg[nra_pkg::QUO_W-1];

endmodule

// File: hdl/nra_back.sv
module nra_back (
    input  logic             clk,
    input  logic             rst_n,
    input  nra_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  nra_pkg::div_t    in_data,
    output logic             advance,
    output logic             result_valid,
    input  logic             result_stall,
    output nra_pkg::result_t result
);

    // address terms stage
    typedef struct packed {
        logic [nra_pkg::ADDR_W-1:0]  base_ch;
        logic [nra_pkg::ADDR_W-1:0]  sy_pitch;
        logic [nra_pkg::PITCH_W-1:0] nc_sx;
        logic [nra_pkg::OFS_W-1:0]   dst_offset;
        logic                        ok;
    } b1_t;

    b1_t              b1_reg, b1_next;
    logic             b1_v_reg;
    nra_pkg::result_t result_next;
    nra_pkg::result_t result_reg;
    nra_pkg::result_t skid_reg;
    logic             result_v_reg;
    logic             skid_v_reg;
    logic             out_free;

    // the whole pipeline moves unless the skid stage is holding a result
    assign advance  = !skid_v_reg;
    assign out_free = !result_v_reg || !result_stall;

    // range check, pitch and channel products
    always_comb
    begin
        b1_next.base_ch    = cfg.src_base + nra_pkg::ADDR_W'(in_data.side.chan);
        b1_next.sy_pitch   = nra_pkg::ADDR_W'(in_data.side.pitch)
                           * nra_pkg::ADDR_W'(in_data.quo_h);
        b1_next.nc_sx      = nra_pkg::PITCH_W'(cfg.num_channels)
                           * nra_pkg::PITCH_W'(in_data.quo_w);
        b1_next.dst_offset = in_data.side.dst_offset;
        b1_next.ok         = in_data.side.ok && !in_data.ovf
                          && (in_data.quo_w < cfg.src_width)
                          && (in_data.quo_h < cfg.src_height);
    end

    // final sum; a rejected item reports address zero
    always_comb
    begin
        result_next.src_address = b1_reg.ok
            ? b1_reg.base_ch + b1_reg.sy_pitch + nra_pkg::ADDR_W'(b1_reg.nc_sx)
            : '0;
        result_next.dst_offset  = b1_reg.dst_offset;
        result_next.valid_res   = b1_reg.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg     <= 1'b0;
            result_v_reg <= 1'b0;
            skid_v_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                b1_v_reg <= in_valid;
            end
            if (out_free)
            begin
                result_v_reg <= skid_v_reg || (advance && b1_v_reg);
                skid_v_reg   <= 1'b0;
            end
            else if (advance && b1_v_reg)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_reg <= b1_next;
        end
        if (out_free)
        begin
            result_reg <= skid_v_reg ? skid_reg : result_next;
        end
        if (!out_free && advance && b1_v_reg)
        begin
            skid_reg <= result_next;
        end
    end

    assign result_valid = result_v_reg;
    assign result       = result_reg;

endmodule

// File: hdl/nearest_resize_address_gen.sv
// Channel   Handshake               Payload
// item      item_valid/item_stall   nra_pkg::item_t   (chan_index, out_row, out_col)
// result    result_valid/result_stall nra_pkg::result_t (src_address, dst_offset, valid_res)
// config    psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One item per cycle while item_stall is low; the result is registered through 18
// register stages (3 front stages, 13 divider stages of one quotient bit each,
// one address stage, output register).
// Reset clears all valid bits and loads the register defaults; nothing to sweep.
// A stalled result is held in the output register, the next one goes to a skid
// register, and the pipeline stops only once the skid register is full.
`include "nearest_resize_address_gen_macros.svh"

module nearest_resize_address_gen #(
    parameter int unsigned MAX_DIM      = nra_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_CHANNELS = nra_pkg::MAX_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nra_pkg::PADDR_W-1:0]   paddr,
    input  logic [nra_pkg::DATA_W-1:0]    pwdata,
    output logic [nra_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  nra_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output nra_pkg::result_t              result
);

    nra_pkg::cfg_t cfg;
    logic          advance;
    logic          front_valid;
    nra_pkg::div_t front_data;
    logic          div_valid;
    nra_pkg::div_t div_data;

    assign item_stall = !advance;

    nra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nra_front #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .in_valid  (item_valid),
        .in_data   (item),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    nra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    nra_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (div_valid),
        .in_data      (div_data),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // an empty output register means the skid stage is empty too
    `NRA_ASSERT_IMP(a_empty_out_no_stall, !result_valid, !item_stall)

    // a rejected coordinate never carries an address
    `NRA_ASSERT_IMP(a_reject_zero_addr, result_valid && !result.valid_res, result.src_address == '0)

    // a full skid stage cannot drain while the output is still stalled
    `NRA_ASSERT_NEXT(a_skid_holds, result_valid && result_stall && item_stall, item_stall)

endmodule
